>>> design/t2tsu_pkg.sv
// ----------------------------------------------------------------------------
// t2tsu_pkg - shared types for the tag-2 triple signed unpacker
// Layout codes, unpacker state and result records, sign-extension helpers.
// ----------------------------------------------------------------------------
package t2tsu_pkg;

	// Layout selected by header bits 7:6
	typedef enum logic [1:0] {
		LAYOUT_TINY   = 2'd0,  // three 2-bit fields in the header
		LAYOUT_NIBBLE = 2'd1,  // 4-bit fields, header plus one byte
		LAYOUT_SIX    = 2'd2,  // 6-bit fields, header plus two bytes
		LAYOUT_SIZED  = 2'd3   // 1..4 little-endian bytes per field
	} layout_t;

	localparam logic [7:0] MASK2 = 8'h03;
	localparam logic [7:0] MASK4 = 8'h0F;
	localparam logic [7:0] MASK6 = 8'h3F;

	typedef struct packed {
		logic           in_group;
		layout_t        layout_kind;
		logic [5:0]     size_codes;
		logic [1:0]     field_slot;
		logic [2:0]     bytes_remaining;
		logic [31:0]    byte_assembly;
		logic [31:0]    held_first;
		logic [31:0]    held_second;
	} unpk_state_t;

	typedef struct packed {
		logic           emit;
		logic [31:0]    value_first;
		logic [31:0]    value_second;
		logic [31:0]    value_third;
	} unpk_result_t;

	function automatic logic [31:0] sext2(input logic [7:0] v);
		return {{30{v[1]}}, v[1:0]};
	endfunction

	function automatic logic [31:0] sext4(input logic [7:0] v);
		return {{28{v[3]}}, v[3:0]};
	endfunction

	function automatic logic [31:0] sext6(input logic [7:0] v);
		return {{26{v[5]}}, v[5:0]};
	endfunction

	// Sign-extend an assembled field of (code + 1) bytes
	function automatic logic [31:0] sext_bytes(input logic [31:0] v, input logic [1:0] code);
		logic [31:0] r;
		unique case (code)
			2'd0:    r = {{24{v[7]}}, v[7:0]};
			2'd1:    r = {{16{v[15]}}, v[15:0]};
			2'd2:    r = {{8{v[23]}}, v[23:0]};
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

>>> design/t2tsu_decode.sv
// ----------------------------------------------------------------------------
// t2tsu_decode - one-byte step of the unpacker
// Next state and the optional completed group for the current byte.
// ----------------------------------------------------------------------------
module t2tsu_decode (
	input  t2tsu_pkg::unpk_state_t  cur,
	input  logic [7:0]              in_byte,
	output t2tsu_pkg::unpk_state_t  nxt,
	output t2tsu_pkg::unpk_result_t res
);
	import t2tsu_pkg::*;

	logic [1:0]  cur_code;
	logic [1:0]  pos;
	logic [2:0]  total;
	logic [2:0]  rem_next;
	logic [31:0] asm_next;
	logic [31:0] field_val;
	logic [1:0]  next_code;

	always_comb begin
		cur_code  = 2'(cur.size_codes >> {cur.field_slot, 1'b0});
		total     = {1'b0, cur_code} + 3'd1;
		pos       = 2'(total - cur.bytes_remaining);
		asm_next  = cur.byte_assembly | ({24'd0, in_byte} << {pos, 3'b000});
		rem_next  = cur.bytes_remaining - 3'd1;
		field_val = sext_bytes(asm_next, cur_code);
		next_code = 2'(cur.size_codes >> {cur.field_slot + 2'd1, 1'b0});
	end

	always_comb begin
		nxt = cur;
		res = '0;
		if (!cur.in_group) begin
			nxt.layout_kind = layout_t'(in_byte[7:6]);
			nxt.in_group    = 1'b1;
			unique case (layout_t'(in_byte[7:6]))
				LAYOUT_TINY: begin
					nxt.in_group     = 1'b0;
					res.emit         = 1'b1;
					res.value_first  = sext2((in_byte >> 4) & MASK2);
					res.value_second = sext2((in_byte >> 2) & MASK2);
					res.value_third  = sext2(in_byte & MASK2);
				end
				LAYOUT_NIBBLE: begin
					nxt.held_first = sext4(in_byte & MASK4);
					nxt.field_slot = 2'd1;
				end
				LAYOUT_SIX: begin
					nxt.held_first = sext6(in_byte & MASK6);
					nxt.field_slot = 2'd1;
				end
				default: begin
					nxt.size_codes      = 6'(in_byte & MASK6);
					nxt.field_slot      = 2'd0;
					nxt.bytes_remaining = {1'b0, in_byte[1:0]} + 3'd1;
					nxt.byte_assembly   = '0;
				end
			endcase
		end else begin
			unique case (cur.layout_kind)
				LAYOUT_NIBBLE: begin
					nxt.in_group     = 1'b0;
					res.emit         = 1'b1;
					res.value_first  = cur.held_first;
					res.value_second = sext4(in_byte >> 4);
					res.value_third  = sext4(in_byte & MASK4);
				end
				LAYOUT_SIX: begin
					if (cur.field_slot == 2'd1) begin
						nxt.held_second = sext6(in_byte & MASK6);
						nxt.field_slot  = 2'd2;
					end else begin
						nxt.in_group     = 1'b0;
						res.emit         = 1'b1;
						res.value_first  = cur.held_first;
						res.value_second = cur.held_second;
						res.value_third  = sext6(in_byte & MASK6);
					end
				end
				LAYOUT_SIZED: begin
					nxt.byte_assembly   = asm_next;
					nxt.bytes_remaining = rem_next;
					if (rem_next == 3'd0) begin
						// field complete: hold it and open the next, or emit
						if (cur.field_slot == 2'd2) begin
							nxt.in_group     = 1'b0;
							res.emit         = 1'b1;
							res.value_first  = cur.held_first;
							res.value_second = cur.held_second;
							res.value_third  = field_val;
						end else begin
							if (cur.field_slot == 2'd0)
								nxt.held_first = field_val;
							else
								nxt.held_second = field_val;
							nxt.field_slot      = cur.field_slot + 2'd1;
							nxt.bytes_remaining = {1'b0, next_code} + 3'd1;
							nxt.byte_assembly   = '0;
						end
					end
				end
				default: begin
					// a tiny-layout group cannot be open; drop the byte
					nxt.in_group = 1'b0;
				end
			endcase
		end
	end

endmodule

>>> design/tag2_triple_signed_unpacker_top.sv
// ----------------------------------------------------------------------------
// tag2_triple_signed_unpacker_top - byte stream to signed value triples
// Input byte register, single-step decode, registered triple output.
// ----------------------------------------------------------------------------
// Takes one byte of the encoded stream per transfer and returns one transfer
// of three sign-extended 32-bit values for each completed group. Header bits
// 7:6 pick the layout: tiny (three 2-bit fields, result from the header
// alone), nibble (header plus one byte), six-bit (header plus two bytes) or
// sized (header bit pairs give each field 1 to 4 little-endian bytes). The
// block sustains one byte per clock while the output is not stalled; each byte
// goes into the input register and is then decoded into the output register.
// A held output that is stalled stops the input register, and so the input
// side, only once a byte is waiting there. No end-of-stream handling: a
// partial group waits for more bytes or is dropped by reset.
module tag2_triple_signed_unpacker_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         in_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value_first,
	output logic signed [31:0] value_second,
	output logic signed [31:0] value_third
);
	import t2tsu_pkg::*;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// group state, held between bytes
	unpk_state_t  state_q;
	unpk_state_t  state_next;
	unpk_result_t res;

	// output register
	logic        out_valid_q;
	logic [31:0] first_q;
	logic [31:0] second_q;
	logic [31:0] third_q;

	logic out_free;   // output register can take a new result
	logic advance;    // byte in the input register is decoded this cycle

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	t2tsu_decode u_decode (
		.cur     (state_q),
		.in_byte (byte_s1),
		.nxt     (state_next),
		.res     (res)
	);

	// state is all zero after reset, matching an empty group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res.emit) begin
			first_q  <= res.value_first;
			second_q <= res.value_second;
			third_q  <= res.value_third;
		end
	end

	assign out_valid    = out_valid_q;
	assign value_first  = first_q;
	assign value_second = second_q;
	assign value_third  = third_q;

endmodule

>>> design/t2tsu_checker.sv
// ----------------------------------------------------------------------------
// t2tsu_checker - port-level checks for the unpacker
// Output hold under stall, stall origin and result latency.
// ----------------------------------------------------------------------------
module t2tsu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] value_first,
	input logic [31:0] value_second,
	input logic [31:0] value_third
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(value_first) && $stable(value_second)
			&& $stable(value_third))
		else $error("stalled result changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled with a free output");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a byte two cycles earlier");

endmodule

bind tag2_triple_signed_unpacker_top t2tsu_checker u_t2tsu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.value_first  (value_first),
	.value_second (value_second),
	.value_third  (value_third)
);
